// ===== sv/vdrw_pkg.sv =====
`default_nettype none
package vdrw_pkg;

	// default sizes of the node store
	localparam int DEF_NODE_CAPACITY = 65536;
	localparam int DEF_MATERIALS     = 256;
	localparam int DEF_LEVELS        = 32;

	localparam int NODE_W  = 16;
	localparam int COUNT_W = 17;
	localparam int COORD_W = 32;
	localparam int MAT_W   = 8;

	localparam logic [COORD_W-1:0] COORD_OFFSET = 32'h8000_0000;

	localparam logic [2:0] ACT_READ   = 3'd0;
	localparam logic [2:0] ACT_SET    = 3'd1;
	localparam logic [2:0] ACT_FILL   = 3'd2;
	localparam logic [2:0] ACT_CKPT   = 3'd3;
	localparam logic [2:0] ACT_SELECT = 3'd4;

	typedef logic [7:0][NODE_W-1:0] row_t;

	typedef struct packed {
		logic [2:0]                action;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [MAT_W-1:0]          material;
		logic [NODE_W-1:0]         root_select;
	} in_word_t;

	typedef struct packed {
		logic [MAT_W-1:0]  material_out;
		logic [NODE_W-1:0] root_out;
		logic              status;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic load;
		logic simple;
		logic walk_mem;
		logic walk_step;
		logic use_mem;
		logic rec_path;
		logic read_done;
		logic up_start;
		logic up_rd;
		logic up_wr;
		logic ckpt_rd;
		logic ckpt_wr;
		logic ckpt_full;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       in_valid;
		logic [2:0] act;
		logic       mat_ok;
		logic       n_mat;
		logic       n_nomem;
		logic       lvl_end;
		logic       lvl_zero;
		logic       ch_eq_nomem;
		logic       ch_eq_mem;
		logic       shared;
		logic       full;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/vdrw_if.sv =====
`default_nettype none
interface vdrw_in_if;
	import vdrw_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vdrw_out_if;
	import vdrw_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/vdrw_ctrl.sv =====
`default_nettype none
module vdrw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  vdrw_pkg::sts_t sts,
	output vdrw_pkg::cmd_t cmd
);
	import vdrw_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DISP  = 9'b000000010,
		ST_WALK  = 9'b000000100,
		ST_WDAT  = 9'b000001000,
		ST_UP_RD = 9'b000010000,
		ST_UP_WR = 9'b000100000,
		ST_CK_RD = 9'b001000000,
		ST_CK_WR = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   is_read;

	assign is_read = (sts.act == ACT_READ);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.act)
					ACT_READ: state_d = ST_WALK;
					ACT_SET:  state_d = sts.mat_ok ? ST_WALK : ST_FIN;
					ACT_CKPT: begin
						if (sts.full) begin
							cmd.ckpt_full = 1'b1;
							state_d       = ST_FIN;
						end else begin
							state_d = ST_CK_RD;
						end
					end
					default: begin
						cmd.simple = 1'b1;
						state_d    = ST_FIN;
					end
				endcase
			end
			ST_WALK: begin
				if (is_read) begin
					if (sts.n_mat || sts.lvl_end) begin
						cmd.read_done = 1'b1;
						state_d       = ST_FIN;
					end else if (sts.n_nomem) begin
						cmd.walk_step = 1'b1;
					end else begin
						cmd.walk_mem = 1'b1;
						state_d      = ST_WDAT;
					end
				end else if (sts.lvl_end) begin
					cmd.up_start = 1'b1;
					state_d      = ST_UP_RD;
				end else begin
					cmd.rec_path = 1'b1;
					if (sts.n_nomem) begin
						if (sts.ch_eq_nomem) state_d = ST_FIN;
						else cmd.walk_step = 1'b1;
					end else begin
						cmd.walk_mem = 1'b1;
						state_d      = ST_WDAT;
					end
				end
			end
			ST_WDAT: begin
				if (!is_read && sts.ch_eq_mem) begin
					state_d = ST_FIN;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.use_mem   = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_UP_RD: begin
				cmd.up_rd = 1'b1;
				state_d   = ST_UP_WR;
			end
			ST_UP_WR: begin
				cmd.up_wr = 1'b1;
				if ((sts.shared && sts.full) || sts.lvl_zero || !sts.shared) state_d = ST_FIN;
				else state_d = ST_UP_RD;
			end
			ST_CK_RD: begin
				cmd.ckpt_rd = 1'b1;
				state_d     = ST_CK_WR;
			end
			ST_CK_WR: begin
				cmd.ckpt_wr = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== sv/vdrw_dp.sv =====
`default_nettype none
module vdrw_dp #(
	parameter int NODE_CAPACITY = vdrw_pkg::DEF_NODE_CAPACITY,
	parameter int MATERIALS     = vdrw_pkg::DEF_MATERIALS,
	parameter int LEVELS        = vdrw_pkg::DEF_LEVELS
) (
	input  logic           clk,
	input  logic           arst_n,
	vdrw_in_if.sink        in_ch,
	vdrw_out_if.source     out_ch,
	input  vdrw_pkg::cmd_t cmd,
	output vdrw_pkg::sts_t sts
);
	import vdrw_pkg::*;

	localparam int IDX_W  = $clog2(NODE_CAPACITY);
	localparam int LVL_CW = $clog2(LEVELS + 1);
	localparam int LVL_IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [NODE_W-1:0]  MAT_LIM = NODE_W'(MATERIALS);
	localparam logic [COUNT_W-1:0] CAP     = COUNT_W'(NODE_CAPACITY);

	// node store, one row of eight children per node
	row_t mem [NODE_CAPACITY];
	row_t rd_row_q;

	logic [2:0]         act_q;
	logic [MAT_W-1:0]   mat_q;
	logic [NODE_W-1:0]  sel_q;
	logic [COORD_W-1:0] ux_q, uy_q, uz_q;
	logic [NODE_W-1:0]  n_q, v_q;
	logic [2:0]         c_q;
	logic [LVL_CW-1:0]  lvl_q;
	logic [COUNT_W-1:0] saved_q, count_q, shend_q;
	logic [NODE_W-1:0]  root_q;
	logic [MAT_W-1:0]   matout_q;
	logic               status_q;
	logic               out_valid_q;
	out_word_t          out_q;
	logic [NODE_W-1:0]  path_n_q [LEVELS];
	logic [2:0]         path_c_q [LEVELS];

	logic [2:0]        walk_c;
	logic              n_mat, n_nomem, shared, full, mat_ok;
	logic [NODE_W-1:0] mat_ext, child_nomem, child_mem, child, append_idx, r_idx;
	logic [LVL_IW-1:0] lvl_idx;
	row_t              wr_row;
	logic              mem_wr, mem_rd, abort;
	logic [IDX_W-1:0]  rd_addr, wr_addr;

	assign walk_c      = {uz_q[COORD_W-1], uy_q[COORD_W-1], ux_q[COORD_W-1]};
	assign mat_ext     = NODE_W'(mat_q);
	assign mat_ok      = mat_ext < MAT_LIM;
	assign n_mat       = n_q < MAT_LIM;
	assign n_nomem     = n_mat || ({1'b0, n_q} >= CAP);
	assign child_nomem = n_mat ? n_q : '0;
	assign child_mem   = rd_row_q[walk_c];
	assign child       = cmd.use_mem ? child_mem : child_nomem;
	assign shared      = {1'b0, n_q} < shend_q;
	assign full        = count_q >= CAP;
	assign lvl_idx     = lvl_q[LVL_IW-1:0];
	assign append_idx  = count_q[NODE_W-1:0];
	assign r_idx       = (cmd.ckpt_wr || shared) ? append_idx : n_q;
	assign abort       = cmd.up_wr && shared && full;

	// row to write: material nodes expand to themselves, out-of-store nodes to zero; up_wr puts v_q in child c_q
	always_comb begin
		if (n_mat) wr_row = {8{n_q}};
		else if (n_nomem) wr_row = '0;
		else wr_row = rd_row_q;
		if (cmd.up_wr) wr_row[c_q] = v_q;
	end

	assign mem_wr  = cmd.ckpt_wr || (cmd.up_wr && (shared ? !full : !n_nomem));
	assign mem_rd  = cmd.walk_mem || cmd.up_rd || cmd.ckpt_rd;
	assign rd_addr = cmd.up_rd ? path_n_q[lvl_idx][IDX_W-1:0] : n_q[IDX_W-1:0];
	assign wr_addr = r_idx[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_rd) rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_wr) mem[wr_addr] <= wr_row;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_W'(MATERIALS);
			shend_q     <= COUNT_W'(MATERIALS);
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.simple) begin
				if (act_q == ACT_FILL && mat_ok) root_q <= mat_ext;
				if (act_q == ACT_SELECT && ({1'b0, sel_q} < count_q)) root_q <= sel_q;
			end
			if (cmd.up_wr) begin
				if (abort) begin
					count_q <= saved_q;
				end else begin
					if (shared) count_q <= count_q + 1'b1;
					if (lvl_q == '0) root_q <= r_idx;
				end
			end
			if (cmd.ckpt_rd) shend_q <= count_q;
			if (cmd.ckpt_wr) begin
				count_q <= count_q + 1'b1;
				root_q  <= append_idx;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= in_ch.data.action;
			mat_q    <= in_ch.data.material;
			sel_q    <= in_ch.data.root_select;
			ux_q     <= in_ch.data.coord_x ^ COORD_OFFSET;
			uy_q     <= in_ch.data.coord_y ^ COORD_OFFSET;
			uz_q     <= in_ch.data.coord_z ^ COORD_OFFSET;
			n_q      <= root_q;
			lvl_q    <= '0;
			saved_q  <= count_q;
			matout_q <= '0;
			status_q <= 1'b0;
		end
		if (cmd.rec_path) begin
			path_n_q[lvl_idx] <= n_q;
			path_c_q[lvl_idx] <= walk_c;
		end
		if (cmd.walk_step) begin
			n_q   <= child;
			lvl_q <= lvl_q + 1'b1;
			ux_q  <= {ux_q[COORD_W-2:0], 1'b0};
			uy_q  <= {uy_q[COORD_W-2:0], 1'b0};
			uz_q  <= {uz_q[COORD_W-2:0], 1'b0};
		end
		if (cmd.read_done) matout_q <= n_mat ? n_q[MAT_W-1:0] : '0;
		if (cmd.up_start) begin
			lvl_q <= lvl_q - 1'b1;
			v_q   <= mat_ext;
		end
		if (cmd.up_rd) begin
			n_q <= path_n_q[lvl_idx];
			c_q <= path_c_q[lvl_idx];
		end
		if (cmd.up_wr) begin
			if (abort) begin
				status_q <= 1'b1;
			end else begin
				v_q   <= r_idx;
				lvl_q <= lvl_q - 1'b1;
			end
		end
		if (cmd.ckpt_full) status_q <= 1'b1;
		if (cmd.out_load) begin
			out_q.material_out <= matout_q;
			out_q.root_out     <= root_q;
			out_q.status       <= status_q;
		end
	end

	assign in_ch.ready  = cmd.in_ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		sts.in_valid    = in_ch.valid;
		sts.act         = act_q;
		sts.mat_ok      = mat_ok;
		sts.n_mat       = n_mat;
		sts.n_nomem     = n_nomem;
		sts.lvl_end     = lvl_q == LVL_CW'(LEVELS);
		sts.lvl_zero    = lvl_q == '0;
		sts.ch_eq_nomem = child_nomem == mat_ext;
		sts.ch_eq_mem   = child_mem == mat_ext;
		sts.shared      = shared;
		sts.full        = full;
		sts.out_free    = !out_valid_q || out_ch.ready;
	end

endmodule
`default_nettype wire

// ===== sv/voxel_dag_read_write_unit.sv =====
// channel   dir   word         fields
// in_ch     in    in_word_t    action, coord_x/y/z, material, root_select
// out_ch    out   out_word_t   material_out, root_out, status
//
// one word at a time; read walks down level by level to a material node or
// the last level, set walks down recording the path and then rewrites it
// back up, cloning shared nodes; checkpoint clones the root node
// arst_n clears the fsm, node count, shared boundary, root and output valid; the
// node store is not cleared, material nodes are synthesised and never read from it
// a new word is taken while the last result still waits on out_ch
`default_nettype none
module voxel_dag_read_write_unit #(
	parameter int NODE_CAPACITY = vdrw_pkg::DEF_NODE_CAPACITY,
	parameter int MATERIALS     = vdrw_pkg::DEF_MATERIALS,
	parameter int LEVELS        = vdrw_pkg::DEF_LEVELS
) (
	input  logic       clk,
	input  logic       arst_n,
	vdrw_in_if.sink    in_ch,
	vdrw_out_if.source out_ch
);
	import vdrw_pkg::*;

	// command and status between the fsm and the datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: walk down, copy-on-write back up, checkpoint clone
	vdrw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// node store, path scratch, counters and result register
	vdrw_dp #(
		.NODE_CAPACITY (NODE_CAPACITY),
		.MATERIALS     (MATERIALS),
		.LEVELS        (LEVELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
	import vdrw_pkg::*;

	localparam int CAP      = DEF_NODE_CAPACITY;
	localparam int MATS     = DEF_MATERIALS;
	localparam int DEPTH    = DEF_LEVELS;
	localparam int LIMIT    = 3000000;
	localparam int TAIL     = 200;
	localparam logic [2:0] ACT_SPARE = 3'd5;

	// idling phases
	localparam int PH_NONE = 0;
	localparam int PH_SEND = 1;
	localparam int PH_RECV = 2;
	localparam int PH_BOTH = 3;

	typedef struct {
		in_word_t w;
		int       phase;
		bit       hold;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	vdrw_in_if  in_ch();
	vdrw_out_if out_ch();

	voxel_dag_read_write_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// shadow copy of the octree store and its bookkeeping
	bit [15:0] dag_kids [0:CAP*8-1];
	int unsigned dag_count;
	int unsigned dag_shared;
	int unsigned dag_root;
	bit [15:0] walk_nodes [0:DEPTH-1];
	bit [2:0]  walk_kids  [0:DEPTH-1];

	stim_t     pending_words [$];
	out_word_t expected_words [$];
	int        n_sent;
	int        n_recv;
	int        cur_phase;
	int        cycles;
	int        errors;
	bit        stim_done;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned kid_of(int unsigned n, int unsigned c);
		if (n < MATS)
			return n;
		if (n >= CAP)
			return 0;
		return dag_kids[n*8 + (c & 7)];
	endfunction

	// append a clone of node n; zero when the store is full
	function automatic bit clone_node(int unsigned n, output int unsigned idx);
		if (dag_count >= CAP)
			return 0;
		for (int c = 0; c < 8; c++)
			dag_kids[dag_count*8 + c] = 16'(kid_of(n, c));
		idx = dag_count;
		dag_count++;
		return 1;
	endfunction

	function automatic bit [2:0] octant(bit [31:0] ux, bit [31:0] uy, bit [31:0] uz, int lvl);
		int s;
		s = 31 - lvl;
		return {uz[s], uy[s], ux[s]};
	endfunction

	function automatic out_word_t apply_action(in_word_t w);
		out_word_t   o;
		bit [31:0]   ux, uy, uz;
		int unsigned n, ch, v, r, saved;
		bit          changed;
		bit [2:0]    c;
		ux = w.coord_x ^ COORD_OFFSET;
		uy = w.coord_y ^ COORD_OFFSET;
		uz = w.coord_z ^ COORD_OFFSET;
		o = '0;
		case (w.action)
			ACT_READ: begin
				n = dag_root;
				for (int i = 0; i < DEPTH && n >= MATS; i++)
					n = kid_of(n, octant(ux, uy, uz, i));
				o.material_out = (n < MATS) ? 8'(n) : 8'd0;
			end
			ACT_SET: begin
				if (w.material < MATS) begin
					n = dag_root;
					saved = dag_count;
					changed = 1;
					// walk down recording the path, stop early on a match
					for (int i = 0; i < DEPTH; i++) begin
						c = octant(ux, uy, uz, i);
						ch = kid_of(n, c);
						walk_nodes[i] = 16'(n);
						walk_kids[i] = c;
						if (ch == w.material) begin
							changed = 0;
							break;
						end
						n = ch;
					end
					if (changed) begin
						v = w.material;
						// rewrite on the way up, cloning shared nodes
						for (int i = DEPTH-1; i >= 0; i--) begin
							n = walk_nodes[i];
							r = n;
							if (n < dag_shared) begin
								if (!clone_node(n, r)) begin
									dag_count = saved;
									o.status = 1'b1;
									break;
								end
							end
							if (r < CAP)
								dag_kids[r*8 + walk_kids[i]] = 16'(v);
							if (i == 0)
								dag_root = r;
							if (r == n)
								break;
							v = r;
						end
					end
				end
			end
			ACT_FILL: begin
				if (w.material < MATS)
					dag_root = w.material;
			end
			ACT_CKPT: begin
				if (dag_count >= CAP)
					o.status = 1'b1;
				else begin
					dag_shared = dag_count;
					if (clone_node(dag_root, r))
						dag_root = r;
				end
			end
			ACT_SELECT: begin
				if (w.root_select < dag_count)
					dag_root = w.root_select;
			end
			default: ;
		endcase
		o.root_out = 16'(dag_root);
		return o;
	endfunction

	task automatic add_word(logic [2:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [7:0] mat, logic [15:0] sel, int ph, bit hold = 0);
		stim_t s;
		s.w.action = act;
		s.w.coord_x = x;
		s.w.coord_y = y;
		s.w.coord_z = z;
		s.w.material = mat;
		s.w.root_select = sel;
		s.phase = ph;
		s.hold = hold;
		expected_words.insert(expected_words.size(), apply_action(s.w));
		pending_words.insert(pending_words.size(), s);
	endtask

	// coordinates clustered round a few anchors so paths share nodes
	logic [31:0] anchors [0:7];

	function automatic logic [31:0] pick_coord(int k);
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return anchors[k] ^ 32'($urandom_range(0, 15));
		if (p < 85)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	initial begin
		int          ph, k, p;
		logic [2:0]  act;
		logic [7:0]  mat;
		logic [15:0] sel;
		for (int i = 0; i < CAP*8; i++)
			dag_kids[i] = (i/8 < MATS) ? 16'(i/8) : 16'd0;
		dag_count = MATS;
		dag_shared = MATS;
		dag_root = 0;
		stim_done = 0;
		for (int i = 0; i < 8; i++)
			anchors[i] = $urandom;

		// directed: extremes, every action, the corner cases
		add_word(ACT_READ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_SET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255, 16'd0, PH_NONE);
		add_word(ACT_SET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd1, 16'd0, PH_NONE);
		add_word(ACT_READ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_READ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_READ, 32'h0, 32'hffff_ffff, 32'h0, 8'd0, 16'd0, PH_NONE);
		// set to the value already there: no change
		add_word(ACT_SET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd1, 16'd0, PH_NONE);
		add_word(ACT_SET, 32'h1234, 32'h0, 32'h0, 8'd0, 16'd0, PH_NONE);
		// unshared nodes rewritten in place
		add_word(ACT_SET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe, 8'd7, 16'd0, PH_NONE);
		add_word(ACT_CKPT, 32'h0, 32'h0, 32'h0, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_SET, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd9, 16'd0, PH_NONE);
		add_word(ACT_READ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd0, 16'd0, PH_NONE);
		// an older inner node as root and a read, then an out-of-range select that is ignored
		add_word(ACT_SELECT, 32'h0, 32'h0, 32'h0, 8'd0, 16'(MATS + 1), PH_NONE);
		add_word(ACT_READ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_SELECT, 32'h0, 32'h0, 32'h0, 8'd0, 16'hffff, PH_NONE);
		// inner node as root
		add_word(ACT_SELECT, 32'h0, 32'h0, 32'h0, 8'd0, 16'(MATS + 20), PH_NONE);
		add_word(ACT_READ, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_FILL, 32'h0, 32'h0, 32'h0, 8'd255, 16'd0, PH_NONE);
		add_word(ACT_FILL, 32'h0, 32'h0, 32'h0, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff,
			PH_NONE);
		add_word(3'd6, 32'h0, 32'h0, 32'h0, 8'd0, 16'd0, PH_NONE);
		add_word(3'd7, 32'h0, 32'h0, 32'h0, 8'd0, 16'd0, PH_NONE);
		add_word(ACT_SELECT, 32'h0, 32'h0, 32'h0, 8'd0, 16'(dag_count - 1), PH_NONE, 1);

		// random: mostly sets and reads round the anchors
		for (int i = 0; i < 480; i++) begin
			ph = (i / 35) % 5;
			if (ph == 4)
				ph = PH_NONE;
			k = $urandom_range(7);
			p = $urandom_range(99);
			if (p < 38)
				act = ACT_SET;
			else if (p < 68)
				act = ACT_READ;
			else if (p < 76)
				act = ACT_FILL;
			else if (p < 83)
				act = ACT_CKPT;
			else if (p < 95)
				act = ACT_SELECT;
			else
				act = 3'($urandom_range(5, 7));
			mat = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			sel = $urandom_range(1) ? 16'($urandom_range(0, dag_count - 1)) : 16'($urandom);
			add_word(act, pick_coord(k), pick_coord(k), pick_coord(k), mat, sel, ph,
				(i % 137) == 100);
		end

		// scattered sets growing the store, then mixed actions under both stalls
		for (int i = 0; i < 40; i++)
			add_word(ACT_SET, $urandom, $urandom, $urandom, 8'($urandom_range(1, 255)), 16'd0,
				PH_NONE);
		add_word(ACT_CKPT, 32'h0, 32'h0, 32'h0, 8'd0, 16'd0, PH_BOTH);
		for (int i = 0; i < 10; i++)
			add_word(3'($urandom_range(0, 4)), $urandom, $urandom, $urandom, 8'($urandom),
				16'($urandom), PH_BOTH);
		stim_done = 1;
	end

	// reset once at the start
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		int    sent_now;
		int    idle_pct;
		stim_t s;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			n_sent <= 0;
			cur_phase <= PH_NONE;
		end else begin
			sent_now = n_sent + ((in_ch.valid && in_ch.ready) ? 1 : 0);
			n_sent <= sent_now;
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_words.size() == 0)
					in_ch.valid <= 1'b0;
				else begin
					s = pending_words[0];
					idle_pct = (s.phase == PH_SEND) ? 63 : (s.phase == PH_BOTH) ? 29 : 0;
					// a held word waits for the block to drain first
					if ((s.hold && n_recv != sent_now) || $urandom_range(99) < idle_pct)
						in_ch.valid <= 1'b0;
					else begin
						void'(pending_words.pop_front());
						in_ch.valid <= 1'b1;
						in_ch.data <= s.w;
						cur_phase <= s.phase;
					end
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		int        stall_pct;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			n_recv <= 0;
			errors = 0;
		end else begin
			stall_pct = (cur_phase == PH_RECV) ? 63 : (cur_phase == PH_BOTH) ? 29 : 0;
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
			if (out_ch.valid && out_ch.ready) begin
				n_recv <= n_recv + 1;
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", out_ch.data);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (out_ch.data.material_out !== e.material_out) begin
						$error("material_out expected %0d got %0d", e.material_out,
							out_ch.data.material_out);
						errors++;
					end
					if (out_ch.data.root_out !== e.root_out) begin
						$error("root_out expected %0d got %0d", e.root_out,
							out_ch.data.root_out);
						errors++;
					end
					if (out_ch.data.status !== e.status) begin
						$error("status expected %0d got %0d", e.status, out_ch.data.status);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL voxel_dag_read_write_unit");
			$finish;
		end
	end

	// end of run: drain, let the block settle, then judge
	initial begin
		cycles = 0;
		wait (stim_done && arst_n);
		wait (pending_words.size() == 0 && !in_ch.valid && expected_words.size() == 0);
		repeat (TAIL) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d result words never arrived", expected_words.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS voxel_dag_read_write_unit");
		else
			$display("FAIL voxel_dag_read_write_unit");
		$finish;
	end
endmodule
`default_nettype wire
